// File: rtl/core/drt_pkg.sv
// Shared constants and types for the distance-vector route table.
package drt_pkg;

    localparam int unsigned TABLE_ENTRIES = 32;
    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
    localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam logic [4:0] METRIC_INF = 5'd16;

    localparam logic [1:0] ACT_ENTRY   = 2'd0;
    localparam logic [1:0] ACT_REQUEST = 2'd1;
    localparam logic [1:0] ACT_TICK    = 2'd2;
    localparam logic [1:0] ACT_UNUSED  = 2'd3;

    localparam logic [1:0] REG_TIMEOUT   = 2'd0;
    localparam logic [1:0] REG_MCAST     = 2'd1;
    localparam logic [1:0] REG_PORT      = 2'd2;

    localparam logic [23:0] TIMEOUT_RST = 24'd180000;
    localparam logic [31:0] MCAST_RST   = 32'hE000_0009;
    localparam logic [15:0] PORT_RST    = 16'd520;

    typedef struct packed {
        logic [31:0] subnet;
        logic [31:0] mask;
        logic [31:0] gateway;
        logic [4:0]  metric;
        logic [23:0] timer;
    } t_entry;

endpackage

// File: rtl/core/distance_vector_route_table.sv
// Distance-vector route table: route update, table dump and timer aging.
// One item is handled at a time. A route entry scans all 32 slots of the
// table memory (one read a cycle), then writes back the result; the last
// entry of a packet may then start a dump. A tick walks the table in the
// same way. A dump skips empty slots and, for each route sent, reads the
// memory and then waits on the output handshake. o_stall is high whenever
// an item is in progress.
module distance_vector_route_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_source_address,
    input  logic [15:0] i_source_port,
    input  logic [31:0] i_offered_subnet,
    input  logic [31:0] i_offered_mask,
    input  logic [31:0] i_offered_metric,
    input  logic        i_final_entry,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_dest_address,
    output logic [15:0] o_dest_port,
    output logic        o_has_route,
    output logic [31:0] o_route_subnet,
    output logic [31:0] o_route_mask,
    output logic [4:0]  o_route_metric,
    output logic        o_dump_last
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_UPD   = 3'd2;
    localparam logic [2:0] S_TICK  = 3'd3;
    localparam logic [2:0] S_DRD   = 3'd4;
    localparam logic [2:0] S_DWAIT = 3'd5;
    localparam logic [2:0] S_DOUT  = 3'd6;

    localparam logic [drt_pkg::CNT_W-1:0] LAST_CNT =
        drt_pkg::CNT_W'(drt_pkg::TABLE_ENTRIES);

    logic [2:0]  r_state;
    logic [23:0] r_timeout;
    logic [31:0] r_mcast;
    logic [15:0] r_port;
    logic        r_changed;
    logic [drt_pkg::TABLE_ENTRIES-1:0] r_valid_bits;

    logic [31:0] r_src;
    logic [31:0] r_subnet;
    logic [31:0] r_mask;
    logic [4:0]  r_metric;
    logic        r_last;

    logic [drt_pkg::CNT_W-1:0] r_idx;
    logic                      r_pend;
    logic [drt_pkg::IDX_W-1:0] r_pidx;
    logic                      r_hit;
    logic [drt_pkg::IDX_W-1:0] r_hidx;
    logic [31:0]               r_hhop;
    logic [4:0]                r_hmet;
    logic                      r_sent;

    logic        r_ovalid;
    logic [31:0] r_dest;
    logic [15:0] r_dport;

    drt_pkg::t_entry mem [drt_pkg::TABLE_ENTRIES];
    drt_pkg::t_entry r_rdata;
    drt_pkg::t_entry wdata;
    logic [drt_pkg::IDX_W-1:0] waddr;
    logic                      we;
    logic [drt_pkg::IDX_W-1:0] raddr;

    logic                      free_any;
    logic [drt_pkg::IDX_W-1:0] free_idx;
    logic [4:0]                new_metric;
    logic                      take_hit;
    logic                      take_new;
    logic                      more_above;
    logic [drt_pkg::IDX_W-1:0] cur;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_dest_address = r_dest;
    assign o_dest_port    = r_dport;

    assign cur   = r_idx[drt_pkg::IDX_W-1:0];
    assign raddr = cur;
    assign new_metric = (r_metric >= drt_pkg::METRIC_INF) ? drt_pkg::METRIC_INF
                                                          : r_metric + 5'd1;
    assign take_hit = r_hit && ((r_hhop == r_src) || (new_metric < r_hmet));
    assign take_new = !r_hit && (new_metric < drt_pkg::METRIC_INF) && free_any;
    assign more_above = |((r_valid_bits >> cur) >> 1);

    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = drt_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid_bits[i]) begin
                free_any = 1'b1;
                free_idx = drt_pkg::IDX_W'(i);
            end
        end
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_pidx;
        wdata = r_rdata;
        if (r_state == S_UPD && (take_hit || take_new)) begin
            we    = 1'b1;
            waddr = r_hit ? r_hidx : free_idx;
            wdata = '{subnet: r_subnet, mask: r_mask, gateway: r_src,
                      metric: new_metric, timer: r_timeout};
        end else if (r_state == S_TICK && r_pend && r_valid_bits[r_pidx] &&
                     r_rdata.timer > 24'd1) begin
            we          = 1'b1;
            wdata.timer = r_rdata.timer - 24'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_timeout    <= drt_pkg::TIMEOUT_RST;
            r_mcast      <= drt_pkg::MCAST_RST;
            r_port       <= drt_pkg::PORT_RST;
            r_changed    <= 1'b0;
            r_valid_bits <= '0;
            r_ovalid     <= 1'b0;
            r_idx        <= '0;
            r_pend       <= 1'b0;
            r_hit        <= 1'b0;
            r_sent       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    drt_pkg::REG_TIMEOUT: r_timeout <= i_cfg_data[23:0];
                    drt_pkg::REG_MCAST:   r_mcast   <= i_cfg_data;
                    drt_pkg::REG_PORT:    r_port    <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            unique case (r_state) inside
                S_IDLE: begin
                    r_idx  <= '0;
                    r_pend <= 1'b0;
                    r_hit  <= 1'b0;
                    r_sent <= 1'b0;
                    if (i_valid) begin
                        r_src    <= i_source_address;
                        r_subnet <= i_offered_subnet;
                        r_mask   <= i_offered_mask;
                        r_metric <= (i_offered_metric >= 32'd16) ? drt_pkg::METRIC_INF
                                                                 : i_offered_metric[4:0];
                        r_last   <= i_final_entry;
                        unique case (i_action)
                            drt_pkg::ACT_ENTRY:   r_state <= S_SCAN;
                            drt_pkg::ACT_REQUEST: begin
                                r_dest  <= i_source_address;
                                r_dport <= i_source_port;
                                r_state <= S_DRD;
                            end
                            drt_pkg::ACT_TICK:    r_state <= S_TICK;
                            default:              r_state <= S_IDLE;
                        endcase
                    end
                end
                S_SCAN, S_TICK: begin
                    r_pend <= (r_idx != LAST_CNT);
                    r_pidx <= cur;
                    if (r_idx != LAST_CNT) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (r_pend && r_valid_bits[r_pidx]) begin
                        if (r_state == S_SCAN) begin
                            if (!r_hit && r_rdata.subnet == r_subnet &&
                                r_rdata.mask == r_mask) begin
                                r_hit  <= 1'b1;
                                r_hidx <= r_pidx;
                                r_hhop <= r_rdata.gateway;
                                r_hmet <= r_rdata.metric;
                            end
                        end else if (r_rdata.timer <= 24'd1) begin
                            r_valid_bits[r_pidx] <= 1'b0;
                        end
                    end
                    if (r_idx == LAST_CNT && !r_pend) begin
                        r_state <= (r_state == S_SCAN) ? S_UPD : S_IDLE;
                    end
                end
                S_UPD: begin
                    r_idx <= '0;
                    if (take_new) begin
                        r_valid_bits[free_idx] <= 1'b1;
                    end
                    if (r_last) begin
                        r_changed <= 1'b0;
                        r_dest    <= r_mcast;
                        r_dport   <= r_port;
                        r_state   <= (r_changed || take_hit || take_new) ? S_DRD
                                                                         : S_IDLE;
                    end else begin
                        r_changed <= r_changed || take_hit || take_new;
                        r_state   <= S_IDLE;
                    end
                end
                S_DRD: begin
                    if (r_idx == LAST_CNT) begin
                        r_ovalid       <= 1'b1;
                        o_has_route    <= 1'b0;
                        o_route_subnet <= '0;
                        o_route_mask   <= '0;
                        o_route_metric <= '0;
                        o_dump_last    <= 1'b1;
                        r_state        <= S_DOUT;
                    end else if (r_valid_bits[cur]) begin
                        r_state <= S_DWAIT;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DWAIT: begin
                    r_ovalid       <= 1'b1;
                    r_sent         <= 1'b1;
                    o_has_route    <= 1'b1;
                    o_route_subnet <= r_rdata.subnet;
                    o_route_mask   <= r_rdata.mask;
                    o_route_metric <= r_rdata.metric;
                    o_dump_last    <= !more_above;
                    r_state        <= S_DOUT;
                end
                S_DOUT: begin
                    if (!i_stall) begin
                        r_ovalid <= 1'b0;
                        if (o_dump_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_DRD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // results appear only while a dump is presenting them
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_state == S_DOUT))
        else $error("result valid outside dump output state");

    // an empty-table result always closes the dump
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_has_route) |-> (o_dump_last && !r_sent))
        else $error("empty-table result not alone in dump");

    // the write-back state is never held
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |=> (r_state != S_UPD))
        else $error("update state held");

endmodule
